// ----- hdl/rcfd_pkg.sv -----
// package: constants, register codes, crc table and stick shaping for the deframer
package rcfd_pkg;

  localparam int unsigned FRAME_BYTES = 15;
  localparam int unsigned PAYLOAD_LEN = 10;
  localparam int unsigned PAYLOAD_BITS = PAYLOAD_LEN * 8;
  localparam int unsigned FILL_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned STICK_W = 11;
  localparam int unsigned DZ_W = 10;
  localparam int unsigned SW_W = 2;
  localparam int unsigned N_STICKS = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] SYNC_FIRST_RST = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd85;
  localparam logic [7:0] END_MARKER_RST = 8'd221;
  localparam logic [STICK_W-1:0] STICK_CENTER_RST = 11'd1024;
  localparam logic [DZ_W-1:0] DEAD_ZONE_RST = 10'd363;

  localparam logic [SW_W-1:0] SAFE_SWITCH_LEFT = 2'd2;
  localparam logic [SW_W-1:0] SAFE_SWITCH_RIGHT = 2'd3;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST   = 3'd0,
    CFG_SYNC_SECOND  = 3'd1,
    CFG_END_MARKER   = 3'd2,
    CFG_STICK_CENTER = 3'd3,
    CFG_DEAD_ZONE    = 3'd4
  } cfg_reg_e;

  typedef logic [PAYLOAD_BITS-1:0][15:0] crc_tab_t;

  // bitwise crc-16/ccitt, msb first; byte 0 sits in data[7:0]
  function automatic logic [15:0] crc16_bytes(input logic [15:0] init,
                                              input logic [PAYLOAD_BITS-1:0] data);
    logic [15:0] crc;
    crc = init;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      crc = crc ^ {data[i*8 +: 8], 8'h00};
      for (int b = 0; b < 8; b++) begin
        if (crc[15]) crc = {crc[14:0], 1'b0} ^ CRC_POLY;
        else         crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

  // contribution of each payload bit to the crc, from a zero start
  function automatic crc_tab_t crc_table();
    crc_tab_t tab;
    logic [PAYLOAD_BITS-1:0] one_hot;
    for (int i = 0; i < PAYLOAD_BITS; i++) begin
      one_hot = '0;
      one_hot[i] = 1'b1;
      tab[i] = crc16_bytes(16'h0000, one_hot);
    end
    return tab;
  endfunction

  // crc is linear: init term xor the columns of the set payload bits
  localparam crc_tab_t CRC_TAB = crc_table();
  localparam logic [15:0] CRC_INIT_TERM = crc16_bytes(CRC_INIT, '0);

  // centre, dead-zone and saturate one raw channel
  function automatic logic signed [STICK_W-1:0] shape_stick(input logic [STICK_W-1:0] raw,
                                                            input logic [STICK_W-1:0] center,
                                                            input logic [DZ_W-1:0] dz);
    logic signed [STICK_W:0] c;
    logic signed [STICK_W:0] dzp;
    logic signed [STICK_W:0] dzn;
    c = $signed({1'b0, raw}) - $signed({1'b0, center});
    dzp = $signed({2'b00, dz});
    dzn = -dzp;
    if (c >= dzn && c <= dzp) begin
      return '0;
    end else if (c > 12'sd1023) begin
      return 11'sd1023;
    end else if (c < -12'sd1024) begin
      return -11'sd1024;
    end else begin
      return $signed(c[STICK_W-1:0]);
    end
  endfunction

endpackage

// ----- hdl/rc_frame_deframer_crc16.sv -----
// top level: sliding-window frame deframer with crc-16 check and stick shaping
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  input    | in        | in_valid_i / in_stall_o | rx_byte_i, burst_start_i
//  result   | out       | out_valid_o/ out_stall_i| stick_a..d_o, switch_*_o, frame_status_o
//  config   | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// one byte is taken per cycle unless in_stall_o is high; the window check runs in the cycle
// after the transfer through the crc xor tree and field compares; a match loads the result register.
// reset empties the window (fill count zero) and loads the register defaults.
// in_stall_o rises only while a matched frame waits for a full, stalled result register.
module rc_frame_deframer_crc16
  import rcfd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  // byte input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  input  logic                      burst_start_i,
  // frame result
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [STICK_W-1:0] stick_a_o,
  output logic signed [STICK_W-1:0] stick_b_o,
  output logic signed [STICK_W-1:0] stick_c_o,
  output logic signed [STICK_W-1:0] stick_d_o,
  output logic [SW_W-1:0]           switch_left_o,
  output logic [SW_W-1:0]           switch_right_o,
  output logic                      frame_status_o
);

  localparam logic [FILL_W-1:0] FillFull = FILL_W'(FRAME_BYTES);

  // configuration registers
  logic [7:0]         sync_first_q, sync_second_q, end_marker_q;
  logic [STICK_W-1:0] stick_center_q;
  logic [DZ_W-1:0]    dead_zone_q;

  // window, fill count and check-pending flag
  logic [7:0]        win_q [FRAME_BYTES];
  logic [7:0]        win_d [FRAME_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              pend_q, pend_d;

  // result register
  logic                      out_valid_q, out_valid_d;
  logic signed [STICK_W-1:0] stick_q [N_STICKS];
  logic signed [STICK_W-1:0] stick_d [N_STICKS];
  logic [SW_W-1:0]           sw_left_q, sw_left_d, sw_right_q, sw_right_d;
  logic                      status_q, status_d;

  logic                    in_xfer, out_free, match, load, blocked, fields_ok;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [15:0]             crc_calc;
  logic [FILL_W-1:0]       fill_base;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q   <= SYNC_FIRST_RST;
      sync_second_q  <= SYNC_SECOND_RST;
      end_marker_q   <= END_MARKER_RST;
      stick_center_q <= STICK_CENTER_RST;
      dead_zone_q    <= DEAD_ZONE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:   sync_first_q   <= cfg_data_i[7:0];
        CFG_SYNC_SECOND:  sync_second_q  <= cfg_data_i[7:0];
        CFG_END_MARKER:   end_marker_q   <= cfg_data_i[7:0];
        CFG_STICK_CENTER: stick_center_q <= cfg_data_i;
        CFG_DEAD_ZONE:    dead_zone_q    <= cfg_data_i[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // payload bytes two to eleven, first byte in the low bits
  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      payload[i*8 +: 8] = win_q[2 + i];
    end
  end

  // crc as an xor tree over the payload bits
  always_comb begin
    crc_calc = CRC_INIT_TERM;
    for (int i = 0; i < PAYLOAD_BITS; i++) begin
      if (payload[i]) crc_calc = crc_calc ^ CRC_TAB[i];
    end
  end

  // frame match on a full window
  assign match = pend_q && (fill_q == FillFull)
              && (win_q[0] == sync_first_q) && (win_q[1] == sync_second_q)
              && (win_q[FRAME_BYTES-1] == end_marker_q)
              && (crc_calc == {win_q[FRAME_BYTES-3], win_q[FRAME_BYTES-2]});

  // range checks on channels and switches
  always_comb begin
    fields_ok = 1'b1;
    for (int k = 0; k < N_STICKS; k++) begin
      if (win_q[3 + 2*k][7:3] != 5'd0) fields_ok = 1'b0;
    end
    if (win_q[10] == 8'd0 || win_q[10][7:2] != 6'd0) fields_ok = 1'b0;
    if (win_q[11] == 8'd0 || win_q[11][7:2] != 6'd0) fields_ok = 1'b0;
  end

  // result values, safe set on reject
  always_comb begin
    for (int k = 0; k < N_STICKS; k++) begin
      if (fields_ok) begin
        stick_d[k] = shape_stick({win_q[3 + 2*k][2:0], win_q[2 + 2*k]},
                                 stick_center_q, dead_zone_q);
      end else begin
        stick_d[k] = '0;
      end
    end
    sw_left_d  = fields_ok ? win_q[10][SW_W-1:0] : SAFE_SWITCH_LEFT;
    sw_right_d = fields_ok ? win_q[11][SW_W-1:0] : SAFE_SWITCH_RIGHT;
    status_d   = fields_ok ? STATUS_OK : STATUS_REJECT;
  end

  // handshake and flow control
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load        = match && out_free;
  assign blocked     = match && !out_free;
  assign in_stall_o  = blocked;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_d = load || (out_valid_q && out_stall_i);
  assign pend_d      = in_xfer || blocked;

  // window shift and fill count; a delivered frame, or a burst start on a byte transfer, empties the window
  always_comb begin
    fill_base = (match || burst_start_i) ? '0 : fill_q;
    fill_d    = fill_q;
    for (int i = 0; i < FRAME_BYTES; i++) win_d[i] = win_q[i];
    if (in_xfer) begin
      fill_d = (fill_base == FillFull) ? fill_base : fill_base + FILL_W'(1);
      for (int i = 0; i < FRAME_BYTES - 1; i++) win_d[i] = win_q[i + 1];
      win_d[FRAME_BYTES-1] = rx_byte_i;
    end else if (load) begin
      fill_d = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // window and result payload registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAME_BYTES; i++) win_q[i] <= win_d[i];
    if (load) begin
      for (int k = 0; k < N_STICKS; k++) stick_q[k] <= stick_d[k];
      sw_left_q  <= sw_left_d;
      sw_right_q <= sw_right_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign stick_a_o      = stick_q[0];
  assign stick_b_o      = stick_q[1];
  assign stick_c_o      = stick_q[2];
  assign stick_d_o      = stick_q[3];
  assign switch_left_o  = sw_left_q;
  assign switch_right_o = sw_right_q;
  assign frame_status_o = status_q;

`ifndef SYNTHESIS
  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // fill count never passes the frame length
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("window fill count out of range");

  // a reject always carries the safe values
  a_reject_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == STATUS_REJECT) |->
      (stick_a_o == '0 && stick_b_o == '0 && stick_c_o == '0 && stick_d_o == '0
       && switch_left_o == SAFE_SWITCH_LEFT && switch_right_o == SAFE_SWITCH_RIGHT))
    else $error("reject result without safe values");

  // a delivered frame empties the window
  a_clear_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (fill_q == '0 || fill_q == FILL_W'(1)))
    else $error("window not emptied after a frame");
`endif

endmodule
